>>> design/tspw_pkg.sv
package tspw_pkg;

  // Phase output precision and number of CORDIC micro-rotations
  localparam int PHASE_FRAC_BITS  = 16;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int ANGLE_TABLE_LEN  = 24;
  localparam int CORDIC_STAGES    =
    (ANGLE_ITERATIONS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN : ANGLE_ITERATIONS;

  // Sample and difference widths
  localparam int SW  = 8;   // one sample
  localparam int D1W = 10;  // 2b - a - c
  localparam int D2W = 9;   // a - c

  // CORDIC datapath widths: X/Y carry the scaled vector plus CORDIC gain,
  // Z counts units of 2^-32 turn with headroom for the half-turn offset
  localparam int XW = 28;
  localparam int ZW = 34;

  // X is the cosine term times 2^16, Y the sine term times sqrt(3) in Q16
  localparam int                   X_SCALE_SHIFT = 16;
  localparam logic signed [XW-1:0] SQRT3_Q16     = XW'(113512);

  // Half a turn in Z units
  localparam logic signed [ZW-1:0] Z_HALF = ZW'(longint'(1) << 31);

  // atan(2^-i) / (2*pi) in units of 2^-32 turn
  localparam logic [31:0] ANGLE_STEP [ANGLE_TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Rounding and saturation of Z down to the phase word
  localparam int                   PHASE_W     = 16;
  localparam int                   PHASE_SHIFT = 32 - PHASE_FRAC_BITS;
  localparam logic signed [ZW-1:0] PHASE_ROUND =
    ZW'(longint'(1) << (31 - PHASE_FRAC_BITS));
  localparam longint PHASE_HI_RAW = (longint'(1) << (PHASE_FRAC_BITS - 1)) - 1;
  localparam longint PHASE_LO_RAW = -(longint'(1) << (PHASE_FRAC_BITS - 1));
  localparam logic signed [ZW-1:0] PHASE_HI =
    ZW'((PHASE_HI_RAW > 32767) ? longint'(32767) : PHASE_HI_RAW);
  localparam logic signed [ZW-1:0] PHASE_LO =
    ZW'((PHASE_LO_RAW < -32768) ? longint'(-32768) : PHASE_LO_RAW);

  // Threshold after reset
  localparam logic [SW-1:0] NOISE_THRESHOLD_RESET = SW'(10);

  // Per-pixel statistics that ride alongside the CORDIC
  typedef struct packed {
    logic          noisy;
    logic [SW-1:0] range;
    logic [SW-1:0] bright;
  } side_t;

endpackage

>>> design/three_step_phase_wrap.sv
// Wrapped phase of a three-step phase-shift pixel stream, plus range, noise flag and brightness.
// Stages: difference, pre-rotation, one per CORDIC micro-rotation, output register.
// Throughput: one word per clock while the output is not stalled.
// Stall: per-stage valid bits, so empty stages keep filling while the output word waits.
// Reset (rst_n low, synchronous): all stages empty, noise threshold back to 10.
module three_step_phase_wrap (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [tspw_pkg::SW-1:0]   in_sample_first,
  input  logic [tspw_pkg::SW-1:0]   in_sample_second,
  input  logic [tspw_pkg::SW-1:0]   in_sample_third,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [tspw_pkg::PHASE_W-1:0] out_wrapped_phase,
  output logic                      out_noisy,
  output logic [tspw_pkg::SW-1:0]   out_intensity_range,
  output logic [tspw_pkg::SW-1:0]   out_brightness,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tspw_pkg::SW-1:0]   cfg_noise_threshold
);

  localparam int NI = tspw_pkg::CORDIC_STAGES;
  localparam int NS = NI + 3;  // diff stage, pre-rotation, NI rotations, output
  localparam int XW = tspw_pkg::XW;
  localparam int ZW = tspw_pkg::ZW;
  localparam int SW = tspw_pkg::SW;

  logic [SW-1:0]                    thr_r;
  logic [NS-1:0]                    v_r;
  logic [NS-1:0]                    en;
  logic signed [tspw_pkg::D1W-1:0]  d1_r;
  logic signed [tspw_pkg::D2W-1:0]  d2_r;
  tspw_pkg::side_t                  side_r [NS-1];
  logic signed [XW-1:0]             x_r [NI+1];
  logic signed [XW-1:0]             y_r [NI+1];
  logic signed [ZW-1:0]             z_r [NI+1];

  logic [SW-1:0]                    mx, mn, rng;
  logic signed [XW-1:0]             x0, y0;
  logic signed [ZW-1:0]             z_sum, z_shr, z_sat;

  // Configuration register: always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= tspw_pkg::NOISE_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_noise_threshold;
    end
  end

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NS-1] = !v_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NS-1];

  // Valid bits travel with the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage 0: max, min, range, noise flag and the two fringe differences
  always_comb begin
    mx = in_sample_first;
    mn = in_sample_first;
    if (in_sample_second > mx) mx = in_sample_second;
    if (in_sample_third > mx)  mx = in_sample_third;
    if (in_sample_second < mn) mn = in_sample_second;
    if (in_sample_third < mn)  mn = in_sample_third;
    rng = mx - mn;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_r <= $signed({1'b0, in_sample_second, 1'b0})
            - $signed({2'b00, in_sample_first})
            - $signed({2'b00, in_sample_third});
      d2_r <= $signed({1'b0, in_sample_first}) - $signed({1'b0, in_sample_third});
      side_r[0] <= '{noisy: (rng <= thr_r), range: rng, bright: mx};
    end
  end

  // Stage 1: scale to Q16 and fold the left half-plane onto the right
  always_comb begin
    x0 = XW'(d1_r) <<< tspw_pkg::X_SCALE_SHIFT;
    y0 = XW'(d2_r) * tspw_pkg::SQRT3_Q16;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (d1_r[tspw_pkg::D1W-1]) begin
        x_r[0] <= -x0;
        y_r[0] <= -y0;
        z_r[0] <= d2_r[tspw_pkg::D2W-1] ? -tspw_pkg::Z_HALF : tspw_pkg::Z_HALF;
      end else begin
        x_r[0] <= x0;
        y_r[0] <= y0;
        z_r[0] <= '0;
      end
      side_r[1] <= side_r[0];
    end
  end

  // Stages 2 .. NI+1: one vectoring micro-rotation each
  for (genvar k = 0; k < NI; k++) begin : g_rot
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] step;

    assign xs   = x_r[k] >>> k;
    assign ys   = y_r[k] >>> k;
    assign step = ZW'(tspw_pkg::ANGLE_STEP[k]);

    always_ff @(posedge clk) begin
      if (en[k+2]) begin
        if (y_r[k][XW-1]) begin
          x_r[k+1] <= x_r[k] - ys;
          y_r[k+1] <= y_r[k] + xs;
          z_r[k+1] <= z_r[k] - step;
        end else if (y_r[k] != '0) begin
          x_r[k+1] <= x_r[k] + ys;
          y_r[k+1] <= y_r[k] - xs;
          z_r[k+1] <= z_r[k] + step;
        end else begin
          x_r[k+1] <= x_r[k];
          y_r[k+1] <= y_r[k];
          z_r[k+1] <= z_r[k];
        end
        side_r[k+2] <= side_r[k+1];
      end
    end
  end

  // Output stage: round to nearest, saturate, register the word
  always_comb begin
    z_sum = z_r[NI] + tspw_pkg::PHASE_ROUND;
    z_shr = z_sum >>> tspw_pkg::PHASE_SHIFT;
    if (z_shr > tspw_pkg::PHASE_HI) begin
      z_sat = tspw_pkg::PHASE_HI;
    end else if (z_shr < tspw_pkg::PHASE_LO) begin
      z_sat = tspw_pkg::PHASE_LO;
    end else begin
      z_sat = z_shr;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_wrapped_phase   <= z_sat[tspw_pkg::PHASE_W-1:0];
      out_noisy           <= side_r[NI+1].noisy;
      out_intensity_range <= side_r[NI+1].range;
      out_brightness      <= side_r[NI+1].bright;
    end
  end

  // A free output slot lets every stage advance, so input is never held off
  a_free_out_accepts : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output slot was free");

  // Input is held off only when the first stage holds a word
  a_stall_needs_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r[0])
    else $error("input stalled with empty first stage");

  // Range never exceeds the brightest sample
  a_range_le_bright : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_intensity_range <= out_brightness))
    else $error("intensity range above brightness");

endmodule
